>>> sv/gpab_pkg.sv
// shared types and constants for the glyph pixel alpha blit
// no dependencies; used by every module of the block

package gpab_pkg;

  // glyph bitmap side limit, positions at or past it are dropped
  localparam int GLYPH_MAX_SIZE = 64;

  // field and register widths
  localparam int COORD_W   = 16;
  localparam int GLYPH_W   = 6;
  localparam int PIXEL_W   = 24;
  localparam int ADDR_W    = 24;
  localparam int CHAN_W    = 8;
  localparam int NUM_CHAN  = 3;
  localparam int SIDE_REG_W = 13;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;

  // alpha value that means fully opaque
  localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEXT_RGB     = 3'd0,
    REG_TEXT_ALPHA   = 3'd1,
    REG_ITALIC_MODE  = 3'd2,
    REG_FRAME_WIDTH  = 3'd3,
    REG_FRAME_HEIGHT = 3'd4
  } cfg_reg_t;

  // stage advance strobes from the pipeline control
  typedef struct packed {
    logic load1;
    logic load2;
    logic load3;
  } pipe_adv_t;

endpackage

>>> sv/gpab_place.sv
// position, clipping and linear address path, three register stages
// depends on gpab_pkg

module gpab_place #(
  parameter int FRAME_MAX_SIDE = 4096,
  parameter int SIDE_W = 13
) (
  input  logic                               clk,
  input  gpab_pkg::pipe_adv_t                adv,
  input  logic                               italic_mode,
  input  logic [gpab_pkg::SIDE_REG_W-1:0]    frame_width,
  input  logic [gpab_pkg::SIDE_REG_W-1:0]    frame_height,
  input  logic                               glyph_bit,
  input  logic [gpab_pkg::GLYPH_W-1:0]       glyph_col,
  input  logic [gpab_pkg::GLYPH_W-1:0]       glyph_row,
  input  logic signed [gpab_pkg::COORD_W-1:0] origin_x,
  input  logic signed [gpab_pkg::COORD_W-1:0] origin_y,
  input  logic                               bold_pass,
  output logic                               we3,
  output logic [gpab_pkg::ADDR_W-1:0]        addr3
);

  localparam int POS_W = gpab_pkg::COORD_W + 2;
  localparam int PROD_W = 2 * SIDE_W;
  localparam int SUM_W = (PROD_W + 1 > gpab_pkg::ADDR_W) ? PROD_W + 1 : gpab_pkg::ADDR_W;

  logic [SIDE_W-1:0]       side_w;
  logic [SIDE_W-1:0]       side_h;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic [POS_W-2:0]        shear;
  logic                    glyph_ok;
  logic                    x_ok;
  logic                    y_ok;

  logic                    we1;
  logic [SIDE_W-1:0]       px1;
  logic [SIDE_W-1:0]       py1;
  logic                    we2;
  logic [SIDE_W-1:0]       px2;
  logic [PROD_W-1:0]       prod2;
  logic [SUM_W-1:0]        sum3;

  // clamp frame sides to the supported maximum
  always_comb begin
    if (32'(frame_width) > FRAME_MAX_SIDE) begin
      side_w = SIDE_W'(FRAME_MAX_SIDE);
    end else begin
      side_w = SIDE_W'(frame_width);
    end
    if (32'(frame_height) > FRAME_MAX_SIDE) begin
      side_h = SIDE_W'(FRAME_MAX_SIDE);
    end else begin
      side_h = SIDE_W'(frame_height);
    end
  end

  // target position with italic shear and bold offset
  always_comb begin
    shear = italic_mode ? (POS_W-1)'(glyph_row[gpab_pkg::GLYPH_W-1:2]) : '0;
    pos_x = POS_W'(origin_x) + $signed({1'b0, (POS_W-1)'(glyph_col)})
          + $signed({1'b0, shear}) + $signed({1'b0, (POS_W-1)'(bold_pass)});
    pos_y = POS_W'(origin_y) + $signed({1'b0, (POS_W-1)'(glyph_row)});
    glyph_ok = (32'(glyph_col) < gpab_pkg::GLYPH_MAX_SIZE)
            && (32'(glyph_row) < gpab_pkg::GLYPH_MAX_SIZE);
    x_ok = !pos_x[POS_W-1] && (pos_x[POS_W-2:0] < (POS_W-1)'(side_w));
    y_ok = !pos_y[POS_W-1] && (pos_y[POS_W-2:0] < (POS_W-1)'(side_h));
  end

  // stage 1: clip decision and in-frame coordinates
  always_ff @(posedge clk) begin
    if (adv.load1) begin
      we1 <= glyph_bit && glyph_ok && x_ok && y_ok;
      px1 <= pos_x[SIDE_W-1:0];
      py1 <= pos_y[SIDE_W-1:0];
    end
  end

  // stage 2: row times stride
  always_ff @(posedge clk) begin
    if (adv.load2) begin
      we2   <= we1;
      px2   <= px1;
      prod2 <= py1 * side_w;
    end
  end

  // stage 3: add column
  always_ff @(posedge clk) begin
    if (adv.load3) begin
      we3  <= we2;
      sum3 <= SUM_W'(prod2) + SUM_W'(px2);
    end
  end

  assign addr3 = sum3[gpab_pkg::ADDR_W-1:0];

endmodule

>>> sv/gpab_blend.sv
// per channel alpha blend, three register stages matching the address path
// depends on gpab_pkg

module gpab_blend (
  input  logic                            clk,
  input  gpab_pkg::pipe_adv_t             adv,
  input  logic [gpab_pkg::PIXEL_W-1:0]    text_rgb,
  input  logic [gpab_pkg::CHAN_W-1:0]     text_alpha,
  input  logic [gpab_pkg::PIXEL_W-1:0]    background_pixel,
  output logic [gpab_pkg::PIXEL_W-1:0]    value3
);

  localparam int CW = gpab_pkg::CHAN_W;
  localparam int NC = gpab_pkg::NUM_CHAN;
  localparam int MIX_W = 2 * CW;

  logic [CW-1:0]    inv_alpha;
  logic [MIX_W-1:0] mix1 [NC];
  logic [CW-1:0]    quot2 [NC];
  logic [MIX_W:0]   div_tmp [NC];

  assign inv_alpha = gpab_pkg::ALPHA_OPAQUE - text_alpha;

  // stage 1: c*a + bg*(255-a) per channel
  always_ff @(posedge clk) begin
    if (adv.load1) begin
      for (int i = 0; i < NC; i++) begin
        mix1[i] <= MIX_W'(text_rgb[i*CW +: CW]) * MIX_W'(text_alpha)
                 + MIX_W'(background_pixel[i*CW +: CW]) * MIX_W'(inv_alpha);
      end
    end
  end

  // divide by 255: (x + (x >> 8) + 1) >> 8 is exact below 65535
  always_comb begin
    for (int i = 0; i < NC; i++) begin
      div_tmp[i] = (MIX_W+1)'(mix1[i]) + (MIX_W+1)'(mix1[i][MIX_W-1:CW])
                 + (MIX_W+1)'(1);
    end
  end

  // stage 2: quotient per channel
  always_ff @(posedge clk) begin
    if (adv.load2) begin
      for (int i = 0; i < NC; i++) begin
        quot2[i] <= div_tmp[i][MIX_W-1:CW];
      end
    end
  end

  // stage 3: opaque text bypasses the blend
  always_ff @(posedge clk) begin
    if (adv.load3) begin
      if (text_alpha == gpab_pkg::ALPHA_OPAQUE) begin
        value3 <= text_rgb;
      end else begin
        value3 <= {quot2[2], quot2[1], quot2[0]};
      end
    end
  end

endmodule

>>> sv/glyph_pixel_alpha_blit.sv
// top level of the glyph pixel alpha blit: config registers and pipeline control
// depends on gpab_pkg, gpab_place and gpab_blend

// Takes one glyph pixel word per clock while in_stall is low and returns one
// result word per input through the three register stages: clip and channel
// products, the row-by-stride multiply and divide by 255, then the column add
// and opaque bypass. A stall on the output back-pressures the input only as far
// as the pipeline has no bubbles. A word with no ink or a target outside the
// frame comes out with write_enable low and zero address and value. The user
// must write configuration only while the pipeline is empty; the block itself
// does not enforce it.

module glyph_pixel_alpha_blit #(
  parameter int FRAME_MAX_SIDE = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write port
  input  logic                                cfg_write,
  input  logic [gpab_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gpab_pkg::CFG_DATA_W-1:0]     cfg_data,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                glyph_bit,
  input  logic [gpab_pkg::GLYPH_W-1:0]        glyph_col,
  input  logic [gpab_pkg::GLYPH_W-1:0]        glyph_row,
  input  logic signed [gpab_pkg::COORD_W-1:0] origin_x,
  input  logic signed [gpab_pkg::COORD_W-1:0] origin_y,
  input  logic                                bold_pass,
  input  logic [gpab_pkg::PIXEL_W-1:0]        background_pixel,
  // output channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                write_enable,
  output logic [gpab_pkg::ADDR_W-1:0]         pixel_address,
  output logic [gpab_pkg::PIXEL_W-1:0]        pixel_value
);

  localparam int SIDE_W = $clog2(FRAME_MAX_SIDE + 1);

  logic [gpab_pkg::PIXEL_W-1:0]    text_rgb;
  logic [gpab_pkg::CHAN_W-1:0]     text_alpha;
  logic                            italic_mode;
  logic [gpab_pkg::SIDE_REG_W-1:0] frame_width;
  logic [gpab_pkg::SIDE_REG_W-1:0] frame_height;

  logic                            v1;
  logic                            v2;
  logic                            v3;
  gpab_pkg::pipe_adv_t             adv;
  logic                            we3;
  logic [gpab_pkg::ADDR_W-1:0]     addr3;
  logic [gpab_pkg::PIXEL_W-1:0]    value3;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      text_rgb     <= '0;
      text_alpha   <= gpab_pkg::ALPHA_OPAQUE;
      italic_mode  <= 1'b0;
      frame_width  <= gpab_pkg::SIDE_REG_W'(640);
      frame_height <= gpab_pkg::SIDE_REG_W'(480);
    end else if (cfg_write) begin
      case (cfg_index)
        gpab_pkg::REG_TEXT_RGB: begin
          text_rgb <= cfg_data[gpab_pkg::PIXEL_W-1:0];
        end
        gpab_pkg::REG_TEXT_ALPHA: begin
          text_alpha <= cfg_data[gpab_pkg::CHAN_W-1:0];
        end
        gpab_pkg::REG_ITALIC_MODE: begin
          italic_mode <= cfg_data[0];
        end
        gpab_pkg::REG_FRAME_WIDTH: begin
          frame_width <= cfg_data[gpab_pkg::SIDE_REG_W-1:0];
        end
        gpab_pkg::REG_FRAME_HEIGHT: begin
          frame_height <= cfg_data[gpab_pkg::SIDE_REG_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // stage advance: a stage moves when empty or when the next one moves
  always_comb begin
    adv.load3 = !v3 || !out_stall;
    adv.load2 = !v2 || adv.load3;
    adv.load1 = !v1 || adv.load2;
  end

  assign in_stall = !adv.load1;

  // valid bits travel with the word
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv.load1) begin
        v1 <= in_valid;
      end
      if (adv.load2) begin
        v2 <= v1;
      end
      if (adv.load3) begin
        v3 <= v2;
      end
    end
  end

  gpab_place #(
    .FRAME_MAX_SIDE (FRAME_MAX_SIDE),
    .SIDE_W         (SIDE_W)
  ) u_place (
    .clk          (clk),
    .adv          (adv),
    .italic_mode  (italic_mode),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .glyph_bit    (glyph_bit),
    .glyph_col    (glyph_col),
    .glyph_row    (glyph_row),
    .origin_x     (origin_x),
    .origin_y     (origin_y),
    .bold_pass    (bold_pass),
    .we3          (we3),
    .addr3        (addr3)
  );

  gpab_blend u_blend (
    .clk              (clk),
    .adv              (adv),
    .text_rgb         (text_rgb),
    .text_alpha       (text_alpha),
    .background_pixel (background_pixel),
    .value3           (value3)
  );

  // dropped words carry zero address and value
  assign out_valid     = v3;
  assign write_enable  = we3;
  assign pixel_address = we3 ? addr3 : '0;
  assign pixel_value   = we3 ? value3 : '0;

endmodule
